### sv/mkpq_pkg.sv
// Package for the min-key priority queue: command and status codes, field widths
// and parameter defaults.
// No dependencies; the interfaces, the queue unit and the testbench use it.
package mkpq_pkg;

	// Parameter defaults
	localparam int CAPACITY_DEF   = 64;
	localparam int KEY_BITS_DEF   = 16;
	localparam int VALUE_BITS_DEF = 16;

	// Fixed field widths
	localparam int CMD_BITS    = 2;
	localparam int STATUS_BITS = 2;
	localparam int STAMP_BITS  = 32;

	// Command codes
	localparam logic [CMD_BITS-1:0] CMD_INSERT     = 2'd0;
	localparam logic [CMD_BITS-1:0] CMD_REMOVE_MIN = 2'd1;
	localparam logic [CMD_BITS-1:0] CMD_REMOVE_KEY = 2'd2;

	// Status codes
	localparam logic [STATUS_BITS-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_BITS-1:0] STATUS_EMPTY     = 2'd1;
	localparam logic [STATUS_BITS-1:0] STATUS_NOT_FOUND = 2'd2;
	localparam logic [STATUS_BITS-1:0] STATUS_FULL      = 2'd3;

endpackage

### sv/mkpq_if.sv
// Valid/ready channel interfaces of the min-key priority queue: request and result.
// Depends on mkpq_pkg for widths and defaults.
interface mkpq_req_if #(
	parameter int KEY_BITS   = mkpq_pkg::KEY_BITS_DEF,
	parameter int VALUE_BITS = mkpq_pkg::VALUE_BITS_DEF
) ();
	logic                            valid;
	logic                            ready;
	logic [mkpq_pkg::CMD_BITS-1:0]   command;
	logic [KEY_BITS-1:0]             key;
	logic [VALUE_BITS-1:0]           value;

	modport source (output valid, command, key, value, input ready);
	modport sink (input valid, command, key, value, output ready);
endinterface

interface mkpq_rsp_if #(
	parameter int KEY_BITS   = mkpq_pkg::KEY_BITS_DEF,
	parameter int VALUE_BITS = mkpq_pkg::VALUE_BITS_DEF,
	parameter int COUNT_BITS = $clog2(mkpq_pkg::CAPACITY_DEF + 1)
) ();
	logic                             valid;
	logic                             ready;
	logic [mkpq_pkg::STATUS_BITS-1:0] status;
	logic [KEY_BITS-1:0]              removed_key;
	logic [VALUE_BITS-1:0]            removed_value;
	logic [COUNT_BITS-1:0]            entry_count;

	modport source (output valid, status, removed_key, removed_value, entry_count,
		input ready);
	modport sink (input valid, status, removed_key, removed_value, entry_count,
		output ready);
endinterface

### sv/min_key_priority_queue_unit.sv
// Min-key priority queue over an unsorted store held in one synchronous RAM.
// Depends on mkpq_pkg, mkpq_if (request and result channels) and mkpq_ram.
//
//   Channel   Direction  Payload                                         Handshake
//   request   in         command, key, value                             valid/ready
//   result    out        status, removed_key, removed_value, entry_count valid/ready
//
// Every request sweeps the whole store, one RAM read per entry through the single
// read port of the entry RAM. After reset a clearing pass writes every entry
// empty, and no request is taken until it ends. A finished result waits in the
// output register; the next request is taken meanwhile and stalls only at its
// own end if that register is still full.
module min_key_priority_queue_unit #(
	parameter int CAPACITY   = mkpq_pkg::CAPACITY_DEF,
	parameter int KEY_BITS   = mkpq_pkg::KEY_BITS_DEF,
	parameter int VALUE_BITS = mkpq_pkg::VALUE_BITS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	mkpq_req_if.sink    request,
	mkpq_rsp_if.source  result
);

	import mkpq_pkg::*;

	localparam int IDX_BITS   = $clog2(CAPACITY);
	localparam int COUNT_BITS = $clog2(CAPACITY + 1);
	// Entry word: occupied flag, insertion stamp, value, key (key in the low bits).
	localparam int VALUE_LSB  = KEY_BITS;
	localparam int STAMP_LSB  = KEY_BITS + VALUE_BITS;
	localparam int ENTRY_BITS = 1 + STAMP_BITS + VALUE_BITS + KEY_BITS;

	localparam logic [IDX_BITS-1:0]   LAST_IDX = IDX_BITS'(CAPACITY - 1);
	localparam logic [COUNT_BITS-1:0] FULL_CNT = COUNT_BITS'(CAPACITY);

	// Sequencer states
	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_WRITE = 3'd4;
	localparam logic [2:0] ST_RESP  = 3'd5;

	logic [2:0]             state_q;
	logic [IDX_BITS-1:0]    scan_addr_q;
	logic [CMD_BITS-1:0]    cmd_q;
	logic [KEY_BITS-1:0]    key_q;
	logic [VALUE_BITS-1:0]  value_q;
	logic [STAMP_BITS-1:0]  next_stamp_q;
	logic [COUNT_BITS-1:0]  held_count_q;

	// Scan pipeline
	logic                   v_s1;
	logic [IDX_BITS-1:0]    idx_s1;
	logic                   v_s2;
	logic [IDX_BITS-1:0]    idx_s2;
	logic                   occ_s2;
	logic                   match_s2;
	logic [KEY_BITS-1:0]    key_s2;
	logic [VALUE_BITS-1:0]  value_s2;
	logic [STAMP_BITS-1:0]  age_s2;

	// Running choice of the scan
	logic                   best_found_q;
	logic [IDX_BITS-1:0]    best_idx_q;
	logic [KEY_BITS-1:0]    best_key_q;
	logic [VALUE_BITS-1:0]  best_value_q;
	logic [STAMP_BITS-1:0]  best_age_q;
	logic                   free_found_q;
	logic [IDX_BITS-1:0]    free_idx_q;

	// Finished result and output register
	logic [STATUS_BITS-1:0] res_status_q;
	logic [KEY_BITS-1:0]    res_key_q;
	logic [VALUE_BITS-1:0]  res_value_q;
	logic                   out_valid_q;
	logic [STATUS_BITS-1:0] out_status_q;
	logic [KEY_BITS-1:0]    out_key_q;
	logic [VALUE_BITS-1:0]  out_value_q;
	logic [COUNT_BITS-1:0]  out_count_q;

	// Memory port signals
	logic                   mem_we;
	logic [IDX_BITS-1:0]    mem_waddr;
	logic [ENTRY_BITS-1:0]  mem_wdata;
	logic                   mem_re;
	logic [ENTRY_BITS-1:0]  mem_rdata;

	logic                   take_best;
	logic                   take_free;
	logic                   is_remove;
	logic                   store_full;
	logic                   store_empty;
	logic                   do_insert;
	logic                   do_remove;
	logic [STATUS_BITS-1:0] wb_status;
	logic                   out_load;

	mkpq_ram #(
		.WIDTH (ENTRY_BITS),
		.DEPTH (CAPACITY)
	) u_entry_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (scan_addr_q),
		.rdata (mem_rdata)
	);

	assign request.ready        = (state_q == ST_IDLE);
	assign result.valid         = out_valid_q;
	assign result.status        = out_status_q;
	assign result.removed_key   = out_key_q;
	assign result.removed_value = out_value_q;
	assign result.entry_count   = out_count_q;

	assign mem_re = (state_q == ST_SCAN);

	// Decisions for the write-back step, made from the finished scan.
	always_comb begin
		is_remove   = (cmd_q == CMD_REMOVE_MIN) || (cmd_q == CMD_REMOVE_KEY);
		store_full  = (held_count_q == FULL_CNT);
		store_empty = (held_count_q == '0);
		do_insert   = (cmd_q == CMD_INSERT) && !store_full && free_found_q;
		do_remove   = is_remove && !store_empty && best_found_q;
		wb_status   = STATUS_OK;
		if (cmd_q == CMD_INSERT && store_full) begin
			wb_status = STATUS_FULL;
		end else if (is_remove && store_empty) begin
			wb_status = STATUS_EMPTY;
		end else if (is_remove && !best_found_q) begin
			wb_status = STATUS_NOT_FOUND;
		end
	end

	// Memory writes: clearing pass, new entry on insert, emptied entry on removal.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = scan_addr_q;
		mem_wdata = '0;
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_WRITE: begin
				if (do_insert) begin
					mem_we    = 1'b1;
					mem_waddr = free_idx_q;
					mem_wdata = {1'b1, next_stamp_q, value_q, key_q};
				end else if (do_remove) begin
					mem_we    = 1'b1;
					mem_waddr = best_idx_q;
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Candidate tests of the compare stage: smallest key, youngest on a tie,
	// and the lowest-numbered free entry.
	always_comb begin
		take_best = v_s2 && match_s2 && (!best_found_q || key_s2 < best_key_q ||
			(key_s2 == best_key_q && age_s2 < best_age_q));
		take_free = v_s2 && !occ_s2 && !free_found_q;
	end

	assign out_load = (state_q == ST_RESP) && (!out_valid_q || result.ready);

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			scan_addr_q  <= '0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			best_found_q <= 1'b0;
			free_found_q <= 1'b0;
			next_stamp_q <= '0;
			held_count_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_SCAN);
			v_s2 <= v_s1;
			if (take_best) begin
				best_found_q <= 1'b1;
			end
			if (take_free) begin
				free_found_q <= 1'b1;
			end
			// The output register refills in the cycle that its old result leaves.
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.valid && result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					if (scan_addr_q == LAST_IDX) begin
						scan_addr_q <= '0;
						state_q     <= ST_IDLE;
					end else begin
						scan_addr_q <= scan_addr_q + IDX_BITS'(1);
					end
				end
				ST_IDLE: begin
					if (request.valid) begin
						scan_addr_q  <= '0;
						best_found_q <= 1'b0;
						free_found_q <= 1'b0;
						state_q      <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					scan_addr_q <= scan_addr_q + IDX_BITS'(1);
					if (scan_addr_q == LAST_IDX) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					if (do_insert) begin
						next_stamp_q <= next_stamp_q + STAMP_BITS'(1);
						held_count_q <= held_count_q + COUNT_BITS'(1);
					end else if (do_remove) begin
						held_count_q <= held_count_q - COUNT_BITS'(1);
					end
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers: request capture, scan pipeline, choice and results.
	always_ff @(posedge clk) begin
		if (request.valid && request.ready) begin
			cmd_q   <= request.command;
			key_q   <= request.key;
			value_q <= request.value;
		end
		idx_s1   <= scan_addr_q;
		idx_s2   <= idx_s1;
		occ_s2   <= mem_rdata[ENTRY_BITS-1];
		key_s2   <= mem_rdata[KEY_BITS-1:0];
		value_s2 <= mem_rdata[VALUE_LSB +: VALUE_BITS];
		age_s2   <= next_stamp_q - mem_rdata[STAMP_LSB +: STAMP_BITS];
		match_s2 <= mem_rdata[ENTRY_BITS-1] &&
			(cmd_q == CMD_REMOVE_MIN || mem_rdata[KEY_BITS-1:0] == key_q);
		if (take_best) begin
			best_idx_q   <= idx_s2;
			best_key_q   <= key_s2;
			best_value_q <= value_s2;
			best_age_q   <= age_s2;
		end
		if (take_free) begin
			free_idx_q <= idx_s2;
		end
		if (state_q == ST_WRITE) begin
			res_status_q <= wb_status;
			res_key_q    <= do_remove ? best_key_q : '0;
			res_value_q  <= do_remove ? best_value_q : '0;
		end
		if (out_load) begin
			out_status_q <= res_status_q;
			out_key_q    <= res_key_q;
			out_value_q  <= res_value_q;
			out_count_q  <= held_count_q;
		end
	end

	// The entry count never passes the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_count_q <= FULL_CNT)
		else $error("entry count above capacity");

	// A refused insert is reported only with a full store.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.status == STATUS_FULL) |-> result.entry_count == FULL_CNT)
		else $error("full status with a store that is not full");

	// An empty status is reported only with no entries held.
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.status == STATUS_EMPTY) |-> result.entry_count == '0)
		else $error("empty status with entries held");

	// A removal by key always picks an entry of that key.
	a_key_match: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE && cmd_q == CMD_REMOVE_KEY && best_found_q)
		|-> best_key_q == key_q)
		else $error("removal by key chose a different key");

	// An insert into a store that is not full always finds a free entry.
	a_free_found: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE && cmd_q == CMD_INSERT && !store_full) |-> free_found_q)
		else $error("no free entry found below capacity");

endmodule

### sv/mkpq_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module mkpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### tb/min_key_priority_queue_unit_tb.sv
// Self-checking testbench for min_key_priority_queue_unit: insert, remove-smallest and
// remove-by-key requests against an in-bench model of the store, with random idling.
// Depends on mkpq_pkg, mkpq_if and the min_key_priority_queue_unit RTL.
module min_key_priority_queue_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mkpq_pkg::*;

	localparam int CAPACITY    = CAPACITY_DEF;
	localparam int KEY_BITS    = KEY_BITS_DEF;
	localparam int VALUE_BITS  = VALUE_BITS_DEF;
	localparam int COUNT_BITS  = $clog2(CAPACITY + 1);
	localparam int HALF_PERIOD = 4;
	localparam int RESET_CYCLES = 8;
	localparam int RANDOM_REQUESTS = 1800;
	localparam int SETTLE_CYCLES = CAPACITY + 10;
	localparam int CYCLE_LIMIT = 600000;
	localparam int REPORT_LIMIT = 10;

	// The one command code that the block ignores
	localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;

	typedef logic [KEY_BITS-1:0]   key_t;
	typedef logic [VALUE_BITS-1:0] value_t;

	typedef struct packed {
		logic [CMD_BITS-1:0] command;
		key_t                key;
		value_t              value;
		logic                drain_first;
		logic                calm;
	} request_t;

	typedef struct packed {
		logic [STATUS_BITS-1:0] status;
		key_t                   removed_key;
		value_t                 removed_value;
		logic [COUNT_BITS-1:0]  entry_count;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n;

	mkpq_req_if #(.KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) req_ch ();
	mkpq_rsp_if #(.KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS),
		.COUNT_BITS(COUNT_BITS)) rsp_ch ();

	min_key_priority_queue_unit #(
		.CAPACITY(CAPACITY),
		.KEY_BITS(KEY_BITS),
		.VALUE_BITS(VALUE_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.request(req_ch),
		.result(rsp_ch)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// Model of the store
	key_t                  store_key [CAPACITY];
	value_t                store_value [CAPACITY];
	logic [STAMP_BITS-1:0] store_stamp [CAPACITY];
	bit                    store_used [CAPACITY];
	logic [STAMP_BITS-1:0] stamp_counter = '0;
	int                    held_entries = 0;

	request_t request_backlog[$];
	outcome_t due_outcomes[$];
	key_t     planned_keys[$];
	int       random_requests = 0;
	int       mismatches = 0;
	int       cycle_count = 0;

	request_t on_offer;
	int       gap_left;
	int       stall_left;
	logic     calm_now;

	// Applies one request to the model and returns the result it must give.
	function automatic outcome_t predict_outcome(input request_t r);
		outcome_t              o;
		int                    slot;
		key_t                  best_key;
		logic [STAMP_BITS-1:0] age;
		logic [STAMP_BITS-1:0] best_age;
		o = '0;
		o.status = STATUS_OK;
		slot = -1;
		best_key = '0;
		best_age = '0;
		case (r.command)
		CMD_INSERT: begin
			for (int i = 0; i < CAPACITY; i++)
				if (!store_used[i] && slot < 0)
					slot = i;
			if (slot < 0) begin
				o.status = STATUS_FULL;
			end else begin
				store_key[slot] = r.key;
				store_value[slot] = r.value;
				store_stamp[slot] = stamp_counter;
				store_used[slot] = 1'b1;
				stamp_counter = stamp_counter + 1;
				held_entries++;
			end
		end
		CMD_REMOVE_MIN, CMD_REMOVE_KEY: begin
			if (held_entries == 0) begin
				o.status = STATUS_EMPTY;
			end else begin
				// Smallest key wins; among equal keys the youngest entry by wrapped age
				for (int i = 0; i < CAPACITY; i++) begin
					if (store_used[i] &&
						(r.command == CMD_REMOVE_MIN || store_key[i] == r.key)) begin
						age = stamp_counter - store_stamp[i];
						if (slot < 0 || store_key[i] < best_key ||
							(store_key[i] == best_key && age < best_age)) begin
							slot = i;
							best_key = store_key[i];
							best_age = age;
						end
					end
				end
				if (slot < 0) begin
					o.status = STATUS_NOT_FOUND;
				end else begin
					o.removed_key = store_key[slot];
					o.removed_value = store_value[slot];
					store_used[slot] = 1'b0;
					held_entries--;
				end
			end
		end
		default: ;
		endcase
		o.entry_count = held_entries[COUNT_BITS-1:0];
		return o;
	endfunction

	// Queues a request and tracks which keys will be held, so that
	// remove-by-key requests can aim at keys that are present.
	function automatic void add_request(input logic [CMD_BITS-1:0] command, input key_t key,
		input value_t value, input logic drain_first, input logic calm);
		request_t r;
		int       pos;
		r.command = command;
		r.key = key;
		r.value = value;
		r.drain_first = drain_first;
		r.calm = calm;
		request_backlog.push_back(r);
		pos = -1;
		case (command)
		CMD_INSERT: begin
			if (planned_keys.size() < CAPACITY)
				planned_keys.push_back(key);
		end
		CMD_REMOVE_MIN: begin
			foreach (planned_keys[i])
				if (pos < 0 || planned_keys[i] < planned_keys[pos])
					pos = i;
		end
		CMD_REMOVE_KEY: begin
			foreach (planned_keys[i])
				if (pos < 0 && planned_keys[i] == key)
					pos = i;
		end
		default: ;
		endcase
		if (pos >= 0)
			planned_keys.delete(pos);
		if (command != CMD_UNUSED)
			random_requests++;
	endfunction

	// Keys drawn from a narrow, a middle or the full range.
	function automatic key_t draw_key(input int spread);
		int pick;
		case (spread)
		0: return key_t'($urandom_range(0, 7));
		1: return key_t'($urandom_range(0, 255));
		default: begin
			pick = $urandom_range(0, 9);
			if (pick == 0)
				return '0;
			if (pick == 1)
				return '1;
			return key_t'($urandom());
		end
		endcase
	endfunction

	function automatic value_t draw_value();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return '0;
		if (pick == 1)
			return '1;
		return value_t'($urandom());
	endfunction

	// Request driver: holds each request until taken, then waits its drawn gap.
	always @(posedge clk or negedge arst_n) begin
		request_t nxt;
		logic     taken;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.command <= CMD_INSERT;
			req_ch.key <= '0;
			req_ch.value <= '0;
			gap_left <= 0;
			calm_now <= 1'b0;
		end else begin
			taken = req_ch.valid && req_ch.ready;
			if (taken)
				due_outcomes.push_back(predict_outcome(on_offer));
			if (req_ch.valid && !taken) begin
				// Request still on offer; leave it as it is.
			end else if (gap_left > 0) begin
				req_ch.valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (request_backlog.size() > 0 &&
				!(request_backlog[0].drain_first && due_outcomes.size() > 0)) begin
				nxt = request_backlog.pop_front();
				on_offer <= nxt;
				req_ch.valid <= 1'b1;
				req_ch.command <= nxt.command;
				req_ch.key <= nxt.key;
				req_ch.value <= nxt.value;
				gap_left <= nxt.calm ? 0 : $urandom_range(0, 3);
				calm_now <= nxt.calm;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// Result monitor: compares each result with the oldest prediction and
	// drops ready for a drawn number of cycles after each one.
	always @(posedge clk or negedge arst_n) begin
		outcome_t seen;
		outcome_t want;
		int       stall;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				seen.status = rsp_ch.status;
				seen.removed_key = rsp_ch.removed_key;
				seen.removed_value = rsp_ch.removed_value;
				seen.entry_count = rsp_ch.entry_count;
				if (due_outcomes.size() == 0) begin
					if (mismatches < REPORT_LIMIT)
						$display("%0t: result with none expected: status %0d key %h value %h count %0d",
							$realtime, seen.status, seen.removed_key, seen.removed_value,
							seen.entry_count);
					mismatches++;
				end else begin
					want = due_outcomes.pop_front();
					if (seen !== want) begin
						if (mismatches < REPORT_LIMIT)
							$display("%0t: expected status %0d key %h value %h count %0d, got status %0d key %h value %h count %0d",
								$realtime, want.status, want.removed_key, want.removed_value,
								want.entry_count, seen.status, seen.removed_key,
								seen.removed_value, seen.entry_count);
						mismatches++;
					end
				end
				stall = calm_now ? 0 : $urandom_range(0, 3);
				if (stall > 0) begin
					rsp_ch.ready <= 1'b0;
					stall_left <= stall;
				end
			end else if (!rsp_ch.ready) begin
				if (stall_left <= 1) begin
					rsp_ch.ready <= 1'b1;
					stall_left <= 0;
				end else begin
					stall_left <= stall_left - 1;
				end
			end
		end
	end

	// Guard against a hung handshake
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		int               phase_no;
		int               kind;
		int               spread;
		int               span;
		int               insert_share;
		int               pick;
		logic             calm;
		logic             drain;
		logic [CMD_BITS-1:0] command;
		key_t             key;

		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.command = CMD_INSERT;
		req_ch.key = '0;
		req_ch.value = '0;
		rsp_ch.ready = 1'b0;

		// Directed requests: empty store, extreme fields, ties, absent keys,
		// the unused command code.
		add_request(CMD_REMOVE_MIN, '0, '0, 1'b0, 1'b0);
		add_request(CMD_REMOVE_KEY, '0, '1, 1'b0, 1'b0);
		add_request(CMD_UNUSED, '1, '1, 1'b0, 1'b0);
		add_request(CMD_INSERT, '1, '1, 1'b0, 1'b0);
		add_request(CMD_INSERT, '0, '0, 1'b0, 1'b0);
		add_request(CMD_INSERT, key_t'(16'h1234), value_t'(16'hAAAA), 1'b0, 1'b0);
		add_request(CMD_INSERT, key_t'(16'h1234), value_t'(16'h5555), 1'b0, 1'b0);
		add_request(CMD_INSERT, key_t'(16'h1234), value_t'(16'h0F0F), 1'b0, 1'b0);
		add_request(CMD_REMOVE_KEY, key_t'(16'h1234), '0, 1'b0, 1'b0);
		add_request(CMD_REMOVE_KEY, key_t'(16'h4321), '0, 1'b0, 1'b0);
		add_request(CMD_REMOVE_MIN, '1, '1, 1'b0, 1'b0);
		add_request(CMD_INSERT, key_t'(16'h1234), '1, 1'b0, 1'b0);
		add_request(CMD_REMOVE_MIN, '0, '0, 1'b0, 1'b0);
		add_request(CMD_REMOVE_MIN, '0, '0, 1'b0, 1'b0);
		add_request(CMD_UNUSED, '0, '0, 1'b0, 1'b0);
		add_request(CMD_REMOVE_KEY, '1, '0, 1'b0, 1'b0);
		add_request(CMD_REMOVE_KEY, '1, '0, 1'b0, 1'b0);
		add_request(CMD_REMOVE_MIN, '0, '0, 1'b0, 1'b0);
		add_request(CMD_REMOVE_MIN, '0, '0, 1'b0, 1'b0);
		random_requests = 0;

		// Random phases: filling past full, draining past empty, or mixed.
		phase_no = 0;
		while (random_requests < RANDOM_REQUESTS) begin
			kind = $urandom_range(0, 2);
			spread = $urandom_range(0, 2);
			calm = ($urandom_range(0, 3) == 0);
			span = (kind == 2) ? $urandom_range(20, 60) : $urandom_range(60, 150);
			insert_share = (kind == 0) ? 85 : ((kind == 1) ? 15 : 50);
			for (int n = 0; n < span; n++) begin
				drain = (n == 0) && (phase_no % 5 == 0);
				pick = $urandom_range(0, 99);
				if (pick < 2) begin
					command = CMD_UNUSED;
					key = key_t'($urandom());
				end else if (pick < insert_share) begin
					command = CMD_INSERT;
					key = draw_key(spread);
				end else if ($urandom_range(0, 1) == 0) begin
					command = CMD_REMOVE_MIN;
					key = key_t'($urandom());
				end else begin
					command = CMD_REMOVE_KEY;
					if (planned_keys.size() > 0 && $urandom_range(0, 9) < 7)
						key = planned_keys[$urandom_range(0, planned_keys.size() - 1)];
					else
						key = draw_key(spread);
				end
				add_request(command, key, draw_value(), drain, calm);
			end
			phase_no++;
		end

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Wait for every request to be taken and every result to arrive
		while (request_backlog.size() > 0 || req_ch.valid || due_outcomes.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0 && due_outcomes.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

### files.f
sv/mkpq_pkg.sv
sv/mkpq_if.sv
sv/mkpq_ram.sv
sv/min_key_priority_queue_unit.sv
tb/min_key_priority_queue_unit_tb.sv
